>>> src/spi_joystick_frame_reader_defines.svh
// Assertion macros for the frame reader sources (included by sjfr_seq.sv).
`ifndef SPI_JOYSTICK_FRAME_READER_DEFINES_SVH
`define SPI_JOYSTICK_FRAME_READER_DEFINES_SVH

`ifndef SYNTH
`define SJFR_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sjfr assertion failed");
`define SJFR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sjfr assertion failed");
`else
`define SJFR_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define SJFR_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

>>> src/sjfr_pkg.sv
package sjfr_pkg;

   localparam int unsigned FRAME_LEN = 5;
   localparam int unsigned STEP_W = 3;

   localparam logic [STEP_W-1:0] STEP_LAST_BYTE = 3'd4;
   localparam logic [STEP_W-1:0] STEP_END = 3'd5;
   localparam logic [STEP_W-1:0] STEP_START = 3'd6;
   localparam logic [STEP_W-1:0] STEP_UNUSED = 3'd7;

   localparam logic [7:0] FIRST_BYTE_MARK = 8'h80;
   localparam logic [1:0] LED_RESET = 2'b11;

   localparam logic [2:0] REG_LED_BITS = 3'd0;

   typedef logic [FRAME_LEN-1:0][7:0] snap_type;

   typedef struct packed {
      logic       select_active;
      logic       send_valid;
      logic [7:0] send_byte;
      logic       frame_done;
   } step_out_type;

endpackage

>>> src/sjfr_if.sv
interface sjfr_req_if;
   logic       valid;
   logic       ready;
   logic       spi_done;
   logic [7:0] rx_byte;

   modport source (output valid, output spi_done, output rx_byte, input ready);
   modport sink (input valid, input spi_done, input rx_byte, output ready);
endinterface

interface sjfr_rsp_if;
   logic              valid;
   logic              ready;
   logic              select_active;
   logic              send_valid;
   logic [7:0]        send_byte;
   logic              frame_done;
   logic [15:0]       x_raw;
   logic [15:0]       y_raw;
   logic signed [4:0] x_position;
   logic signed [4:0] y_position;
   logic              stick_pressed;
   logic              button_one;
   logic              button_two;

   modport source (
      output valid, output select_active, output send_valid, output send_byte,
      output frame_done, output x_raw, output y_raw, output x_position,
      output y_position, output stick_pressed, output button_one, output button_two,
      input ready
   );
   modport sink (
      input valid, input select_active, input send_valid, input send_byte,
      input frame_done, input x_raw, input y_raw, input x_position,
      input y_position, input stick_pressed, input button_one, input button_two,
      output ready
   );
endinterface

>>> src/spi_joystick_frame_reader.sv
// A result is registered when its poll tick is accepted, shown the next cycle.
// Throughput: one tick per cycle while rsp_bus is ready; the output register
// is refilled in the same cycle it is drained, so ticks stream without bubbles.
// Reset (synchronous, active high) deselects the joystick, zeroes the snapshot,
// sets the LED bits to 3 and arms the sequencer to start a new frame.
module spi_joystick_frame_reader (
   input  logic        clock,
   input  logic        reset,
   sjfr_req_if.sink    req_bus,
   sjfr_rsp_if.source  rsp_bus,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import sjfr_pkg::*;

   logic              accept;
   step_out_type      step_out;
   snap_type          snap_next;
   logic [1:0]        led_bits_ff;
   logic              rsp_valid_ff;
   step_out_type      step_ff;
   snap_type          snap_ff;
   logic signed [4:0] x_position_in;
   logic signed [4:0] y_position_in;
   logic signed [4:0] x_position_ff;
   logic signed [4:0] y_position_ff;
   logic              reg_hit;

   assign pready = 1'b1;
   assign reg_hit = ({paddr[2], 2'b00} == REG_LED_BITS);
   assign prdata = reg_hit ? {30'd0, led_bits_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         led_bits_ff <= LED_RESET;
      end else if (psel && penable && pwrite && reg_hit) begin
         led_bits_ff <= pwdata[1:0];
      end
   end

   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign accept = req_bus.valid && req_bus.ready;

   sjfr_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .spi_done  (req_bus.spi_done),
      .rx_byte   (req_bus.rx_byte),
      .led_bits  (led_bits_ff),
      .step_out  (step_out),
      .snap_next (snap_next)
   );

   sjfr_map u_map_x (
      .raw      ({snap_next[1], snap_next[0]}),
      .position (x_position_in)
   );

   sjfr_map u_map_y (
      .raw      ({snap_next[3], snap_next[2]}),
      .position (y_position_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         step_ff <= step_out;
         snap_ff <= snap_next;
         x_position_ff <= x_position_in;
         y_position_ff <= y_position_in;
      end
   end

   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.select_active = step_ff.select_active;
   assign rsp_bus.send_valid = step_ff.send_valid;
   assign rsp_bus.send_byte = step_ff.send_byte;
   assign rsp_bus.frame_done = step_ff.frame_done;
   assign rsp_bus.x_raw = {snap_ff[1], snap_ff[0]};
   assign rsp_bus.y_raw = {snap_ff[3], snap_ff[2]};
   assign rsp_bus.x_position = x_position_ff;
   assign rsp_bus.y_position = y_position_ff;
   assign rsp_bus.stick_pressed = snap_ff[4][0];
   assign rsp_bus.button_one = snap_ff[4][1];
   assign rsp_bus.button_two = snap_ff[4][2];

endmodule

>>> src/sjfr_map.sv
module sjfr_map (
   input  logic [15:0]       raw,
   output logic signed [4:0] position
);
   logic [16:0] offset;
   logic        negative;
   logic [16:0] magnitude;
   logic [20:0] product;
   logic [4:0]  quotient;
   logic [4:0]  mapped;

   // The quotient by 30 uses the reciprocal 2185 / 65536, exact below 420.
   always_comb begin
      offset = {1'b0, raw} - 17'd512;
      negative = offset[16];
      magnitude = negative ? (17'd0 - offset) : offset;
      product = 21'(magnitude[8:0]) * 21'd2185;
      quotient = product[20:16];
      if (magnitude >= 17'd420) begin
         mapped = 5'd10;
      end else if (quotient >= 5'd4) begin
         mapped = quotient - 5'd4;
      end else begin
         mapped = 5'd0;
      end
      position = negative ? signed'(5'd0 - mapped) : signed'(mapped);
   end
endmodule

>>> src/sjfr_seq.sv
`include "spi_joystick_frame_reader_defines.svh"

module sjfr_seq (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic                  spi_done,
   input  logic [7:0]            rx_byte,
   input  logic [1:0]            led_bits,
   output sjfr_pkg::step_out_type step_out,
   output sjfr_pkg::snap_type     snap_next
);
   import sjfr_pkg::*;

   logic [STEP_W-1:0] step_ff;
   logic [STEP_W-1:0] step_in;
   logic              select_ff;
   logic              select_in;
   snap_type          frame_buffer_ff;
   snap_type          frame_snapshot_ff;
   snap_type          frame_snapshot_in;
   logic              buffer_write;

   always_comb begin
      step_in = step_ff;
      select_in = select_ff;
      frame_snapshot_in = frame_snapshot_ff;
      buffer_write = 1'b0;
      step_out = '0;
      case (step_ff) inside
         [3'd0:STEP_LAST_BYTE]: begin
            if (spi_done) begin
               buffer_write = 1'b1;
               step_out.send_valid = (step_ff != STEP_LAST_BYTE);
               step_in = step_ff + 3'd1;
            end
         end
         STEP_END: begin
            select_in = 1'b0;
            frame_snapshot_in = frame_buffer_ff;
            step_out.frame_done = 1'b1;
            step_in = STEP_START;
         end
         default: begin
            select_in = 1'b1;
            step_out.send_valid = 1'b1;
            step_out.send_byte = FIRST_BYTE_MARK | {6'd0, led_bits};
            step_in = 3'd0;
         end
      endcase
      step_out.select_active = select_in;
      snap_next = frame_snapshot_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_START;
         select_ff <= 1'b0;
         frame_snapshot_ff <= '0;
      end else if (accept) begin
         step_ff <= step_in;
         select_ff <= select_in;
         frame_snapshot_ff <= frame_snapshot_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && buffer_write) begin
         frame_buffer_ff[step_ff] <= rx_byte;
      end
   end

   `SJFR_ASSERT_IMPLIES(a_step_reachable, clock, reset, 1'b1, step_ff != STEP_UNUSED)
   `SJFR_ASSERT_NEXT(a_end_deselects, clock, reset, accept && step_ff == STEP_END, !select_ff)
   `SJFR_ASSERT_NEXT(a_wait_holds, clock, reset,
      step_ff <= STEP_LAST_BYTE && !(accept && spi_done), $stable(step_ff))
   `SJFR_ASSERT_IMPLIES(a_start_selects, clock, reset,
      accept && step_ff == STEP_START, select_in && step_out.send_valid)

endmodule
